>>> rtl/pfx_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and status codes for the postfix evaluator.
// No dependencies; the evaluator and the divider refer to this package by scoped names.
package pfx_pkg;

	localparam int VALUE_WIDTH = 32;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [7:0]             char_t;
	typedef logic [2:0]             status_t;

	localparam value_t RADIX = value_t'(10);

	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_PLUS  = 8'h2B;
	localparam char_t CH_MINUS = 8'h2D;
	localparam char_t CH_STAR  = 8'h2A;
	localparam char_t CH_SLASH = 8'h2F;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_UNDERFLOW = 3'd1;
	localparam status_t ST_OVERFLOW  = 3'd2;
	localparam status_t ST_DIVZERO   = 3'd3;
	localparam status_t ST_BADCHAR   = 3'd4;
	localparam status_t ST_EMPTY     = 3'd5;

	function automatic logic is_digit(input char_t c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_operator(input char_t c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
	endfunction

endpackage

>>> rtl/postfix_expression_evaluator.sv
`timescale 1ns / 1ps
// Postfix expression evaluator: top level, sequencer, stack pointer and ALU.
// Depends on pfx_pkg, pfx_stack_ram and pfx_divider.
//
//  channel  | handshake                  | word
//  ---------+----------------------------+-------------------------------------
//  char     | char_valid / char_stall    | char_code[7:0], is_last
//  result   | result_valid / result_stall| value[31:0], depth_left[4:0], status
//
// Per character: a digit is folded into the number in S_IDLE, a space or bad character
// passes S_PUSH, + - * pass S_PUSH, S_OPRD and S_OPEX, and / also waits in S_DIV on the
// one-bit-per-cycle divider unless the divisor is zero. The last character adds S_EMIT to
// form the result, a digit also S_PUSH since its number is pushed first; S_OPRD covers the stack RAM's registered read.
// Reset (arst_n low) empties the stack and clears the error; no clearing pass.
// A waiting result does not block characters; only the next result stalls until it goes.
module postfix_expression_evaluator #(
	parameter int STACK_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [7:0]         char_code,
	input  logic               is_last,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] value,
	output logic [4:0]         depth_left,
	output logic [2:0]         status
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PUSH = 3'd1;
	localparam logic [2:0] S_OPRD = 3'd2;
	localparam logic [2:0] S_OPEX = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	// control state
	logic [2:0]       state_q;
	logic [CW-1:0]    count_q;
	pfx_pkg::value_t  acc_q;
	logic             pending_q;
	pfx_pkg::status_t err_q;
	logic             result_valid_q;

	// payload registers
	pfx_pkg::char_t   char_q;
	logic             last_q;
	pfx_pkg::value_t  top_q;
	logic signed [31:0] value_q;
	logic [4:0]       depth_q;
	pfx_pkg::status_t status_q;

	logic             char_acc;
	logic             full;
	logic [CW-1:0]    count_m1;
	logic [CW-1:0]    count_m2;
	logic [31:0]      count_ext;
	logic [2:0]       done_state;
	pfx_pkg::value_t  acc_next;
	pfx_pkg::status_t push_err;
	logic             bad_char;
	logic             do_push;
	logic             can_load;

	logic             mem_we;
	logic             mem_re;
	pfx_pkg::value_t  mem_rdata;
	pfx_pkg::value_t  alu_res;

	logic             div_start;
	logic             div_busy;
	logic             div_done;
	pfx_pkg::value_t  div_quo;

	assign char_stall = (state_q != S_IDLE);
	assign char_acc   = char_valid && !char_stall;

	assign full      = (count_q == CW'(STACK_DEPTH));
	assign count_m1  = count_q - CW'(1);
	assign count_m2  = count_q - CW'(2);
	assign count_ext = 32'(count_q);

	// the low nibble of an ASCII digit is its value
	assign acc_next = acc_q * pfx_pkg::RADIX + pfx_pkg::value_t'(char_code[3:0]);

	assign bad_char = !pfx_pkg::is_digit(char_q) && !pfx_pkg::is_operator(char_q)
		&& (char_q != pfx_pkg::CH_SPACE);
	assign do_push  = pending_q && !full;

	// a dropped push is reported ahead of a bad character in the same step
	always_comb begin
		if (pending_q && full) begin
			push_err = pfx_pkg::ST_OVERFLOW;
		end else if (bad_char) begin
			push_err = pfx_pkg::ST_BADCHAR;
		end else begin
			push_err = pfx_pkg::ST_OK;
		end
	end

	assign done_state = last_q ? S_EMIT : S_IDLE;
	assign can_load   = !result_valid_q || !result_stall;

	// the top of stack stays in top_q; spill the old top on a push
	assign mem_we = (state_q == S_PUSH) && do_push && (count_q != '0);
	// fetch the operand below the top; the FSM never reads in the write cycle
	assign mem_re = (state_q == S_OPRD);

	pfx_stack_ram #(
		.DEPTH(STACK_DEPTH),
		.WIDTH(pfx_pkg::VALUE_WIDTH)
	) u_stack (
		.clk  (clk),
		.we   (mem_we),
		.waddr(count_m1[AW-1:0]),
		.wdata(top_q),
		.re   (mem_re),
		.raddr(count_m2[AW-1:0]),
		.rdata(mem_rdata)
	);

	// a comes from the RAM, b is the top of stack
	always_comb begin
		case (char_q)
			pfx_pkg::CH_PLUS:  alu_res = mem_rdata + top_q;
			pfx_pkg::CH_MINUS: alu_res = mem_rdata - top_q;
			default:           alu_res = mem_rdata * top_q;
		endcase
	end

	assign div_start = (state_q == S_OPEX) && (char_q == pfx_pkg::CH_SLASH)
		&& (top_q != '0);

	pfx_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(mem_rdata),
		.divisor (top_q),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			acc_q          <= '0;
			pending_q      <= 1'b0;
			err_q          <= pfx_pkg::ST_OK;
			result_valid_q <= 1'b0;
		end else begin
			// load a new result word, or drop the one just taken
			if ((state_q == S_EMIT) && can_load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (char_acc) begin
						if (pfx_pkg::is_digit(char_code)) begin
							acc_q     <= acc_next;
							pending_q <= 1'b1;
							if (is_last) begin
								state_q <= S_PUSH;
							end
						end else begin
							state_q <= S_PUSH;
						end
					end
				end
				S_PUSH: begin
					// end the pending number, keep only the first error
					if (do_push) begin
						count_q <= count_q + CW'(1);
					end
					if (err_q == pfx_pkg::ST_OK) begin
						err_q <= push_err;
					end
					acc_q     <= '0;
					pending_q <= 1'b0;
					state_q   <= pfx_pkg::is_operator(char_q) ? S_OPRD : done_state;
				end
				S_OPRD: begin
					if (count_q < CW'(2)) begin
						if (err_q == pfx_pkg::ST_OK) begin
							err_q <= pfx_pkg::ST_UNDERFLOW;
						end
						state_q <= done_state;
					end else begin
						state_q <= S_OPEX;
					end
				end
				S_OPEX: begin
					if (char_q == pfx_pkg::CH_SLASH) begin
						if (top_q == '0) begin
							// leave both operands in place
							if (err_q == pfx_pkg::ST_OK) begin
								err_q <= pfx_pkg::ST_DIVZERO;
							end
							state_q <= done_state;
						end else begin
							state_q <= S_DIV;
						end
					end else begin
						count_q <= count_m1;
						state_q <= done_state;
					end
				end
				S_DIV: begin
					if (div_done) begin
						count_q <= count_m1;
						state_q <= done_state;
					end
				end
				S_EMIT: begin
					// hold until the output register is free, then clear
					if (can_load) begin
						count_q <= '0;
						err_q   <= pfx_pkg::ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (char_acc) begin
			char_q <= char_code;
			last_q <= is_last;
		end
		if ((state_q == S_PUSH) && do_push) begin
			top_q <= acc_q;
		end else if ((state_q == S_OPEX) && (char_q != pfx_pkg::CH_SLASH)) begin
			top_q <= alu_res;
		end else if ((state_q == S_DIV) && div_done) begin
			top_q <= div_quo;
		end
		if ((state_q == S_EMIT) && can_load) begin
			value_q <= (count_q != '0) ? top_q : '0;
			depth_q <= count_ext[4:0];
			if (err_q != pfx_pkg::ST_OK) begin
				status_q <= err_q;
			end else if (count_q == '0) begin
				status_q <= pfx_pkg::ST_EMPTY;
			end else begin
				status_q <= pfx_pkg::ST_OK;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign value        = value_q;
	assign depth_left   = depth_q;
	assign status       = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == S_DIV))
		else $error("divider running outside the divide wait");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> ($past(state_q) == S_EMIT))
		else $error("result raised outside the emit step");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (status == pfx_pkg::ST_EMPTY)) |-> (depth_left == 5'd0))
		else $error("empty status with values left");

endmodule

>>> rtl/pfx_stack_ram.sv
`timescale 1ns / 1ps
// Value stack storage: one write port, one read port, registered read data.
// Standalone; the entries below the top of stack live here, the top in a register.
module pfx_stack_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/pfx_divider.sv
`timescale 1ns / 1ps
// Signed truncating divider, restoring, one quotient bit per cycle.
// Depends on pfx_pkg for the value width and type.
module pfx_divider (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  pfx_pkg::value_t dividend,
	input  pfx_pkg::value_t divisor,
	output logic            busy,
	output logic            done,
	output pfx_pkg::value_t quotient
);

	localparam int W    = pfx_pkg::VALUE_WIDTH;
	localparam int CNTW = $clog2(W);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic            neg_q;
	pfx_pkg::value_t quo_q;
	pfx_pkg::value_t rem_q;
	pfx_pkg::value_t div_q;

	logic [W:0]      rem_shift;
	logic [W:0]      trial;
	pfx_pkg::value_t mag_a;
	pfx_pkg::value_t mag_b;

	assign mag_a     = dividend[W-1] ? -dividend : dividend;
	assign mag_b     = divisor[W-1] ? -divisor : divisor;
	assign rem_shift = {rem_q, quo_q[W-1]};
	assign trial     = rem_shift - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift the dividend out of quo_q while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag_a;
			div_q <= mag_b;
			rem_q <= '0;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? -quo_q : quo_q;

endmodule
